// File: rtl/core/ffca_pkg.sv
// Shared constants, types and helpers for the first-fit coalescing allocator.
package ffca_pkg;

    localparam int HEAP_BYTES     = 8388608;
    localparam int FREE_SLOTS     = 64;
    localparam int ACTIVE_SLOTS   = 64;
    localparam int ALIGN_LOG2     = 4;
    localparam int ALIGN_BYTES    = 1 << ALIGN_LOG2;
    localparam int OVERHEAD_BYTES = 21;

    localparam int ADDR_W  = 48;
    localparam int CNT64_W = 64;
    localparam int OFF_W   = $clog2(HEAP_BYTES + 1);
    localparam int NEED_W  = OFF_W + 2;
    localparam int FIDX_W  = $clog2(FREE_SLOTS + 1);
    localparam int AIDX_W  = $clog2(ACTIVE_SLOTS);
    localparam int SCAN_CYCLES = (FREE_SLOTS > ACTIVE_SLOTS) ? FREE_SLOTS : ACTIVE_SLOTS;
    localparam int SCNT_W  = $clog2(SCAN_CYCLES);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ARRAY = 2'd2;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_NO_MEM   = 3'd1;
    localparam logic [2:0] STAT_OUTSIDE  = 3'd2;
    localparam logic [2:0] STAT_INACTIVE = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] len;
    } free_ent_t;

    typedef struct packed {
        logic              hit;
        logic [FIDX_W-1:0] idx;
        free_ent_t         cur;
        free_ent_t         prev;
    } free_scan_t;

    typedef struct packed {
        logic              set_en;
        logic [FIDX_W-1:0] set_idx;
        free_ent_t         set_ent;
        logic              del_en;
        logic              ins_en;
        logic [FIDX_W-1:0] shift_idx;
    } free_cmd_t;

    typedef struct packed {
        logic              hit;
        logic [AIDX_W-1:0] idx;
        logic [OFF_W-1:0]  size;
    } act_scan_t;

    typedef struct packed {
        logic              wr_en;
        logic              clr_en;
        logic [AIDX_W-1:0] idx;
        logic [OFF_W-1:0]  start;
        logic [OFF_W-1:0]  size;
    } act_cmd_t;

    function automatic logic [NEED_W-1:0] round_block(input logic [OFF_W-1:0] user);
        logic [NEED_W-1:0] t;
        t = NEED_W'(user) + NEED_W'(OVERHEAD_BYTES + ALIGN_BYTES - 1);
        return t & ~NEED_W'(ALIGN_BYTES - 1);
    endfunction

endpackage

// File: rtl/core/ffca_free_cell.sv
// One free-extent cell: holds an extent, edits it, and forwards the scan record.
module ffca_free_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ffca_pkg::FIDX_W-1:0] cell_index,
    input  ffca_pkg::free_ent_t       left,
    input  ffca_pkg::free_ent_t       right,
    input  ffca_pkg::free_cmd_t       cmd,
    input  logic                      scan_free,
    input  logic [ffca_pkg::NEED_W-1:0] need,
    input  logic [ffca_pkg::OFF_W-1:0]  off,
    input  ffca_pkg::free_scan_t      scan_in,
    output ffca_pkg::free_scan_t      scan_out,
    output ffca_pkg::free_ent_t       ent
);

    ffca_pkg::free_ent_t  ent_reg;
    ffca_pkg::free_ent_t  ent_next;
    ffca_pkg::free_scan_t scan_reg;
    ffca_pkg::free_scan_t scan_next;

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.hit)
        begin
            if (scan_free)
            begin
                if (ent_reg.valid && (ent_reg.start <= off))
                begin
                    scan_next.prev = ent_reg;
                end
                else
                begin
                    scan_next.hit = 1'b1;
                    scan_next.idx = cell_index;
                    scan_next.cur = ent_reg;
                end
            end
            else if (ent_reg.valid && (ffca_pkg::NEED_W'(ent_reg.len) >= need))
            begin
                scan_next.hit = 1'b1;
                scan_next.idx = cell_index;
                scan_next.cur = ent_reg;
            end
        end
    end

    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.set_en && (cmd.set_idx == cell_index))
        begin
            ent_next = cmd.set_ent;
        end
        else if (cmd.del_en && (cell_index >= cmd.shift_idx))
        begin
            ent_next = right;
        end
        else if (cmd.ins_en && (cell_index > cmd.shift_idx))
        begin
            ent_next = left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg.valid <= (cell_index == '0);
            ent_reg.start <= '0;
            ent_reg.len   <= ffca_pkg::OFF_W'(ffca_pkg::HEAP_BYTES);
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;
    assign ent      = ent_reg;

endmodule

// File: rtl/core/ffca_active_cell.sv
// One active-block cell: holds a live block and forwards the slot search record.
module ffca_active_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ffca_pkg::AIDX_W-1:0] cell_index,
    input  ffca_pkg::act_cmd_t          cmd,
    input  logic                        scan_free,
    input  logic [ffca_pkg::OFF_W-1:0]  off,
    input  ffca_pkg::act_scan_t         scan_in,
    output ffca_pkg::act_scan_t         scan_out
);

    logic                       valid_reg;
    logic [ffca_pkg::OFF_W-1:0] start_reg;
    logic [ffca_pkg::OFF_W-1:0] size_reg;
    ffca_pkg::act_scan_t        scan_reg;
    ffca_pkg::act_scan_t        scan_next;
    logic                       sel;

    assign sel = (cmd.idx == cell_index);

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.hit)
        begin
            if (scan_free ? (valid_reg && (start_reg == off)) : !valid_reg)
            begin
                scan_next.hit  = 1'b1;
                scan_next.idx  = cell_index;
                scan_next.size = size_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && cmd.wr_en)
        begin
            valid_reg <= 1'b1;
        end
        else if (sel && cmd.clr_en)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && cmd.wr_en)
        begin
            start_reg <= cmd.start;
            size_reg  <= cmd.size;
        end
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;

endmodule

// File: rtl/core/first_fit_coalescing_allocator.sv
// Top level of the first-fit coalescing heap allocator.
// Each transaction takes one request and returns one result. The free extents and the
// active blocks sit in two rows of cells that pass a search record one cell per clock,
// so every allocate or free that reaches the search walks the longer row once; null,
// zero-size and out-of-heap requests skip the search and go straight to the result.
// The next request is taken as soon as the previous result is placed in the output
// register.
module first_fit_coalescing_allocator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // request_size, element_count, block_address
    input  logic [111:0] s_axis_tdata,
    // opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // granted_address, active_count, total_count, fail_count,
    // active_bytes, total_bytes, fail_bytes
    output logic [431:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser
);

    localparam int FS = ffca_pkg::FREE_SLOTS;
    localparam int AS = ffca_pkg::ACTIVE_SLOTS;
    localparam int OW = ffca_pkg::OFF_W;
    localparam int CW = ffca_pkg::CNT64_W;
    localparam int AW = ffca_pkg::ADDR_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_LEN   = 3'd5;
    localparam logic [2:0] S_EVAL  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [47:0] base_reg;
    logic [1:0]  op_reg;
    logic [31:0] size_reg, count_reg;
    logic [47:0] addr_reg;
    logic [CW-1:0] user_reg;
    logic [ffca_pkg::NEED_W-1:0] need_reg;
    logic [ffca_pkg::NEED_W-1:0] len_need;
    logic          big_reg;
    logic [OW-1:0] off_reg;
    logic [OW-1:0] len_reg;
    logic          scan_free_reg;
    logic [ffca_pkg::SCNT_W-1:0] scnt_reg;
    logic [2:0]    res_status_reg, res_status_next;
    logic [AW-1:0] res_addr_reg, res_addr_next;
    logic [CW-1:0] act_cnt_reg, tot_cnt_reg, fail_cnt_reg;
    logic [CW-1:0] act_bytes_reg, tot_bytes_reg, fail_bytes_reg;
    logic [CW-1:0] act_cnt_next, tot_cnt_next, fail_cnt_next;
    logic [CW-1:0] act_bytes_next, tot_bytes_next, fail_bytes_next;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [431:0]  out_data_reg;
    logic          out_load;

    ffca_pkg::free_scan_t fscan [FS+1];
    ffca_pkg::free_ent_t  fent  [FS+2];
    ffca_pkg::act_scan_t  ascan [AS+1];
    ffca_pkg::free_cmd_t  fcmd;
    ffca_pkg::act_cmd_t   acmd;
    logic [FS-1:0]        fvalid;

    ffca_pkg::free_scan_t fr;
    ffca_pkg::act_scan_t  ar;
    logic [AW-1:0] off48;
    logic          prev_join, next_join, table_full;
    logic [OW-1:0] p_minus1_len;

    assign fr = fscan[FS];
    assign ar = ascan[AS];

    assign fscan[0] = '{hit: 1'b0, idx: ffca_pkg::FIDX_W'(FS), cur: '0, prev: '0};
    assign ascan[0] = '0;
    assign fent[0]    = '0;
    assign fent[FS+1] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < FS; gi++)
        begin : g_free
            ffca_free_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_index(ffca_pkg::FIDX_W'(gi)),
                .left      (fent[gi]),
                .right     (fent[gi+2]),
                .cmd       (fcmd),
                .scan_free (scan_free_reg),
                .need      (need_reg),
                .off       (off_reg),
                .scan_in   (fscan[gi]),
                .scan_out  (fscan[gi+1]),
                .ent       (fent[gi+1])
            );
            assign fvalid[gi] = fent[gi+1].valid;
        end
        for (gi = 0; gi < AS; gi++)
        begin : g_act
            ffca_active_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_index(ffca_pkg::AIDX_W'(gi)),
                .cmd       (acmd),
                .scan_free (scan_free_reg),
                .off       (off_reg),
                .scan_in   (ascan[gi]),
                .scan_out  (ascan[gi+1])
            );
        end
    endgenerate

    assign table_full   = fvalid[FS-1];
    assign off48        = addr_reg - base_reg;
    assign prev_join    = fr.prev.valid &&
                          ((OW+1)'(fr.prev.start) + (OW+1)'(fr.prev.len) == (OW+1)'(off_reg));
    assign next_join    = fr.hit && fr.cur.valid &&
                          ((OW+1)'(off_reg) + (OW+1)'(len_reg) == (OW+1)'(fr.cur.start));
    assign p_minus1_len = fr.prev.len + len_reg;
    assign len_need     = ffca_pkg::round_block(ar.size);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        act_cnt_next    = act_cnt_reg;
        tot_cnt_next    = tot_cnt_reg;
        fail_cnt_next   = fail_cnt_reg;
        act_bytes_next  = act_bytes_reg;
        tot_bytes_next  = tot_bytes_reg;
        fail_bytes_next = fail_bytes_reg;
        fcmd            = '0;
        acmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_status_next = ffca_pkg::STAT_OK;
                    res_addr_next   = '0;
                    priority if (s_axis_tuser == ffca_pkg::OP_ALLOC ||
                                 s_axis_tuser == ffca_pkg::OP_ARRAY)
                    begin
                        state_next = S_MUL;
                    end
                    else if (s_axis_tuser == ffca_pkg::OP_FREE)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = (user_reg == '0) ? S_FIN : S_SCAN;
            end
            S_CHECK:
            begin
                priority if (addr_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (off48 >= AW'(ffca_pkg::HEAP_BYTES))
                begin
                    res_status_next = ffca_pkg::STAT_OUTSIDE;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scnt_reg == ffca_pkg::SCNT_W'(ffca_pkg::SCAN_CYCLES - 1))
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_FIN;
                if (!scan_free_reg)
                begin
                    priority if (!ar.hit || big_reg || !fr.hit)
                    begin
                        res_status_next = ar.hit ? ffca_pkg::STAT_NO_MEM : ffca_pkg::STAT_FULL;
                        fail_cnt_next   = fail_cnt_reg + CW'(1);
                        fail_bytes_next = fail_bytes_reg + user_reg;
                    end
                    else
                    begin
                        if (ffca_pkg::NEED_W'(fr.cur.len) > need_reg)
                        begin
                            fcmd.set_en        = 1'b1;
                            fcmd.set_idx       = fr.idx;
                            fcmd.set_ent.valid = 1'b1;
                            fcmd.set_ent.start = fr.cur.start + need_reg[OW-1:0];
                            fcmd.set_ent.len   = fr.cur.len - need_reg[OW-1:0];
                        end
                        else
                        begin
                            fcmd.del_en    = 1'b1;
                            fcmd.shift_idx = fr.idx;
                        end
                        acmd.wr_en     = 1'b1;
                        acmd.idx       = ar.idx;
                        acmd.start     = fr.cur.start;
                        acmd.size      = user_reg[OW-1:0];
                        res_addr_next  = base_reg + AW'(fr.cur.start);
                        act_cnt_next   = act_cnt_reg + CW'(1);
                        tot_cnt_next   = tot_cnt_reg + CW'(1);
                        act_bytes_next = act_bytes_reg + user_reg;
                        tot_bytes_next = tot_bytes_reg + user_reg;
                    end
                end
                else if (!ar.hit)
                begin
                    res_status_next = ffca_pkg::STAT_INACTIVE;
                end
                else if (!prev_join && !next_join && table_full)
                begin
                    res_status_next = ffca_pkg::STAT_FULL;
                end
                else
                begin
                    priority if (prev_join && next_join)
                    begin
                        fcmd.set_en        = 1'b1;
                        fcmd.set_idx       = fr.idx - ffca_pkg::FIDX_W'(1);
                        fcmd.set_ent       = fr.prev;
                        fcmd.set_ent.len   = p_minus1_len + fr.cur.len;
                        fcmd.del_en        = 1'b1;
                        fcmd.shift_idx     = fr.idx;
                    end
                    else if (prev_join)
                    begin
                        fcmd.set_en        = 1'b1;
                        fcmd.set_idx       = fr.idx - ffca_pkg::FIDX_W'(1);
                        fcmd.set_ent       = fr.prev;
                        fcmd.set_ent.len   = p_minus1_len;
                    end
                    else if (next_join)
                    begin
                        fcmd.set_en        = 1'b1;
                        fcmd.set_idx       = fr.idx;
                        fcmd.set_ent.valid = 1'b1;
                        fcmd.set_ent.start = off_reg;
                        fcmd.set_ent.len   = fr.cur.len + len_reg;
                    end
                    else
                    begin
                        fcmd.set_en        = 1'b1;
                        fcmd.set_idx       = fr.idx;
                        fcmd.set_ent.valid = 1'b1;
                        fcmd.set_ent.start = off_reg;
                        fcmd.set_ent.len   = len_reg;
                        fcmd.ins_en        = 1'b1;
                        fcmd.shift_idx     = fr.idx;
                    end
                    acmd.clr_en    = 1'b1;
                    acmd.idx       = ar.idx;
                    act_cnt_next   = act_cnt_reg - CW'(1);
                    act_bytes_next = act_bytes_reg - CW'(ar.size);
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= 48'h0000_1000_0000;
            act_cnt_reg    <= '0;
            tot_cnt_reg    <= '0;
            fail_cnt_reg   <= '0;
            act_bytes_reg  <= '0;
            tot_bytes_reg  <= '0;
            fail_bytes_reg <= '0;
            out_valid_reg  <= 1'b0;
            scnt_reg       <= '0;
            scan_free_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            act_cnt_reg    <= act_cnt_next;
            tot_cnt_reg    <= tot_cnt_next;
            fail_cnt_reg   <= fail_cnt_next;
            act_bytes_reg  <= act_bytes_next;
            tot_bytes_reg  <= tot_bytes_next;
            fail_bytes_reg <= fail_bytes_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_SCAN)
            begin
                scnt_reg <= scnt_reg + ffca_pkg::SCNT_W'(1);
            end
            else
            begin
                scnt_reg <= '0;
            end
            if (state_reg == S_PREP)
            begin
                scan_free_reg <= 1'b0;
            end
            else if (state_reg == S_CHECK)
            begin
                scan_free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg    <= s_axis_tuser;
            size_reg  <= s_axis_tdata[31:0];
            count_reg <= s_axis_tdata[63:32];
            addr_reg  <= s_axis_tdata[111:64];
        end
        if (state_reg == S_MUL)
        begin
            user_reg <= (op_reg == ffca_pkg::OP_ARRAY) ? (CW'(size_reg) * CW'(count_reg))
                                                       : CW'(size_reg);
        end
        if (state_reg == S_PREP)
        begin
            big_reg  <= (user_reg > CW'(ffca_pkg::HEAP_BYTES));
            need_reg <= ffca_pkg::round_block(user_reg[OW-1:0]);
        end
        if (state_reg == S_CHECK)
        begin
            off_reg <= off48[OW-1:0];
        end
        if (state_reg == S_LEN)
        begin
            len_reg <= len_need[OW-1:0];
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= {fail_bytes_reg, tot_bytes_reg, act_bytes_reg,
                               fail_cnt_reg, tot_cnt_reg, act_cnt_reg, res_addr_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != S_IDLE))
        else $error("Accepted transaction did not start processing.");

    a_free_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, fvalid} + (FS+1)'(1)))
        else $error("Free extent cells are not packed from the head.");

    a_fin_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == S_IDLE) && m_axis_tvalid)
        else $error("Result load did not return to idle.");

    a_scan_keys_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scnt_reg != '0) |-> $stable(scan_free_reg) &&
            (scan_free_reg ? $stable(off_reg) : $stable(need_reg)))
        else $error("Search keys changed during a sweep.");

endmodule
